[src/ssnd_pkg.sv]
// ssnd_pkg: widths, codes, segment patterns and the decimal constants
// for the seven-segment display core. No dependencies.
`default_nettype none

package ssnd_pkg;

    localparam int VALUE_W = 16;
    localparam int DOT_W   = 3;
    localparam int SEG_W   = 8;
    localparam int SEL_W   = 2;

    typedef logic [SEG_W-1:0] t_seg;

    // opcodes
    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_TICK = 1'b1;

    localparam t_seg SEG_MINUS     = 8'hBF;
    localparam t_seg SEG_BLANK     = 8'hFF;
    localparam t_seg SEG_DOT_CLEAR = 8'h7F;

    // floor(x / 10) == (x * DIV10_MUL) >> DIV10_SHIFT, exact for x <= 32768
    localparam logic [15:0] DIV10_MUL   = 16'd52429;
    localparam int          DIV10_SHIFT = 19;

    function automatic t_seg seg_encode(input logic [3:0] digit);
        t_seg pat;
        begin
            unique case (digit)
                4'd0:    pat = 8'hC0;
                4'd1:    pat = 8'hF9;
                4'd2:    pat = 8'hA4;
                4'd3:    pat = 8'hB0;
                4'd4:    pat = 8'h99;
                4'd5:    pat = 8'h92;
                4'd6:    pat = 8'h82;
                4'd7:    pat = 8'hF8;
                4'd8:    pat = 8'h80;
                4'd9:    pat = 8'h90;
                default: pat = SEG_BLANK;
            endcase
            return pat;
        end
    endfunction

endpackage

`default_nettype wire

[src/ssnd_if.sv]
// Handshake channels of the display core: command items in, segment items out.
// Depends on ssnd_pkg.
`default_nettype none

interface ssnd_in_if;
    import ssnd_pkg::*;
    logic                      valid;
    logic                      ready;
    logic                      opcode;
    logic signed [VALUE_W-1:0] value;
    logic [DOT_W-1:0]          dot_position;

    modport source (output valid, output opcode, output value, output dot_position,
                    input ready);
    modport sink   (input valid, input opcode, input value, input dot_position,
                    output ready);
endinterface

interface ssnd_out_if;
    import ssnd_pkg::*;
    logic             valid;
    logic             ready;
    logic [SEG_W-1:0] segments;
    logic [SEL_W-1:0] digit_select;

    modport source (output valid, output segments, output digit_select, input ready);
    modport sink   (input valid, input segments, input digit_select, output ready);
endinterface

`default_nettype wire

[src/seven_segment_number_display_core.sv]
// Multiplexed seven-segment display core: decimal conversion into a digit
// store and scan output. Depends on ssnd_pkg and ssnd_if.
//
//  channel  | dir | handshake     | payload
//  ---------+-----+---------------+-----------------------------------
//  i_in     | in  | valid/ready   | opcode, value, dot_position
//  o_out    | out | valid/ready   | segments, digit_select
//  cfg      | in  | i_cfg_wr_en   | i_cfg_wr_data (blank_leading)
//
// A tick item leaves its result in the output register.
// A load item is captured, then converted digit by digit
// through the shared divide-by-ten unit (reciprocal multiply and subtract).
// i_in.ready is low while a conversion runs or the output register is full
// and not being taken. Reset (synchronous) fills the store with minus signs.
`default_nettype none

module seven_segment_number_display_core #(
    parameter int DIGITS = 4
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    ssnd_in_if.sink   i_in,
    ssnd_out_if.source o_out,
    input  wire logic i_cfg_wr_en,
    input  wire logic i_cfg_wr_data
);
    import ssnd_pkg::*;

    localparam int IW = (DIGITS > 1) ? $clog2(DIGITS) : 1;
    localparam logic [IW-1:0] LAST_IDX = IW'(DIGITS - 1);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_CONV = 1'b1;

    logic              r_state;
    logic              r_blank;
    t_seg              r_store [DIGITS];
    logic [IW-1:0]     r_scan;
    logic [IW-1:0]     r_digit;
    logic [15:0]       r_mag;
    logic              r_minus;
    logic [DOT_W-1:0]  r_dot;
    logic              r_out_valid;
    t_seg              r_seg;
    logic [SEL_W-1:0]  r_sel;

    logic              accept;
    logic              tick_accept;
    logic [15:0]       in_mag;
    logic [31:0]       prod;
    logic [15:0]       quot;
    logic [15:0]       rem;
    logic              keep;
    t_seg              pat;
    t_seg              pat_dot;

    assign i_in.ready  = (r_state == ST_IDLE) && (!r_out_valid || o_out.ready);
    assign accept      = i_in.valid && i_in.ready;
    assign tick_accept = accept && (i_in.opcode == OP_TICK);

    // magnitude; the most negative value negates onto itself, i.e. 32768
    assign in_mag = i_in.value[VALUE_W-1] ? 16'(~i_in.value + 16'sd1) : 16'(i_in.value);

    // shared divide-by-ten unit
    assign prod = r_mag * DIV10_MUL;
    assign quot = 16'(prod[31:DIV10_SHIFT]);
    assign rem  = r_mag - 16'((quot << 3) + (quot << 1));

    assign keep = !r_blank || (r_mag != 16'd0) || (r_digit == '0)
                  || (4'(r_digit) < 4'(r_dot));

    always_comb begin
        if (keep) begin
            pat = seg_encode(rem[3:0]);
        end else if (r_minus) begin
            pat = SEG_MINUS;
        end else begin
            pat = SEG_BLANK;
        end
        pat_dot = (4'(r_dot) == 4'(r_digit) + 4'd1) ? (pat & SEG_DOT_CLEAR) : pat;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_blank     <= 1'b1;
            r_scan      <= '0;
            r_digit     <= '0;
            r_out_valid <= 1'b0;
            for (int k = 0; k < DIGITS; k++) begin
                r_store[k] <= SEG_MINUS;
            end
        end else begin
            if (i_cfg_wr_en) begin
                r_blank <= i_cfg_wr_data;
            end
            if (tick_accept) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && o_out.ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (accept) begin
                        if (i_in.opcode == OP_TICK) begin
                            r_seg       <= r_store[r_scan];
                            r_sel       <= SEL_W'(r_scan);
                            r_scan      <= (r_scan == LAST_IDX) ? '0 : r_scan + 1'b1;
                        end else begin
                            r_mag   <= in_mag;
                            r_minus <= i_in.value[VALUE_W-1] && r_blank;
                            r_dot   <= i_in.dot_position;
                            r_digit <= '0;
                            r_state <= ST_CONV;
                        end
                    end
                end
                ST_CONV: begin
                    r_store[r_digit] <= pat_dot;
                    r_mag            <= quot;
                    if (!keep) begin
                        r_minus <= 1'b0;
                    end
                    if (r_digit == LAST_IDX) begin
                        r_state <= ST_IDLE;
                    end else begin
                        r_digit <= r_digit + 1'b1;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.segments     = r_seg;
    assign o_out.digit_select = r_sel;

endmodule

`default_nettype wire
